>>> sv/spch_pkg.sv
// ----------------------------------------------------------------------------
// spch_pkg
// Shared types and constants for the sorted-point convex hull block.
// ----------------------------------------------------------------------------
package spch_pkg;

   // coordinate width, fixed by the 16-bit fields on both streams
   localparam int COORD_BITS = 16;

   typedef enum logic [3:0] {
      ST_LOAD,      // taking points
      ST_EMIT0,     // emit point 0
      ST_DN_INIT,   // load ref and initial best (last point)
      ST_DN_SCAN,   // scan candidates downward
      ST_DN_DONE,   // best is committed; maybe emit
      ST_UP_INIT,
      ST_UP_SCAN,
      ST_UP_DONE,
      ST_FINISH,    // mark last result
      ST_WAIT       // wait for output register to drain
   } state_type;

   // slope classes, ordered for comparison
   typedef enum logic [1:0] {
      CLS_NAN    = 2'd0,
      CLS_NEGINF = 2'd1,
      CLS_FINITE = 2'd2,
      CLS_POSINF = 2'd3
   } slope_cls_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_STORE,     // write input point
      CMD_SET_REF,   // ref = store[pos], best init from ref and idx (sets best idx)
      CMD_CAND,      // compare candidate at idx against best
      CMD_COMMIT,    // pos = best
      CMD_EMIT_POS,  // emit store[pos]
      CMD_CLEAR      // reset count, overflow and pos
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       up;       // reversed differences
      logic [5:0] idx;      // read index for SET_REF best / candidate
   } ctl_type;

endpackage

>>> sv/spch_datapath.sv
// ----------------------------------------------------------------------------
// spch_datapath
// Point store, slope compare unit and position/best registers.
// ----------------------------------------------------------------------------
module spch_datapath import spch_pkg::*; #(
   parameter int MAX_POINTS = 32,
   parameter int IDX_BITS   = 5,
   parameter int CNT_BITS   = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ctl_type                      ctl,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   output logic [CNT_BITS-1:0]          count,
   output logic [CNT_BITS-1:0]          pos,
   output logic                         best_nan,
   output logic                         best_finite,
   output logic                         overflow,
   output logic signed [COORD_BITS-1:0] sel_x,
   output logic signed [COORD_BITS-1:0] sel_y
);
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
   logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];

   logic [CNT_BITS-1:0] count_ff, count_in, pos_ff, pos_in, best_ff, best_in;
   logic                ovf_ff, ovf_in;
   logic signed [COORD_BITS-1:0] ref_x_ff, ref_y_ff;
   logic signed [DW-1:0] bnum_ff, bden_ff, bnum_in, bden_in;
   slope_cls_type        bcls_ff, bcls_in;

   logic signed [COORD_BITS-1:0] rx, ry;
   logic signed [DW-1:0]         dx, dy, cnum, cden;
   slope_cls_type                ccls;
   logic signed [PW-1:0]         lhs, rhs;
   logic                         less;

   assign rx = mem_x[ctl.idx[IDX_BITS-1:0]];
   assign ry = mem_y[ctl.idx[IDX_BITS-1:0]];

   // reference from the store at SET_REF, else from register
   always_comb begin
      logic signed [COORD_BITS-1:0] fx, fy;
      fx = (ctl.cmd == CMD_SET_REF) ? mem_x[pos_ff[IDX_BITS-1:0]] : ref_x_ff;
      fy = (ctl.cmd == CMD_SET_REF) ? mem_y[pos_ff[IDX_BITS-1:0]] : ref_y_ff;
      if (ctl.up) begin
         dx = DW'(fx) - DW'(rx);
         dy = DW'(fy) - DW'(ry);
      end else begin
         dx = DW'(rx) - DW'(fx);
         dy = DW'(ry) - DW'(fy);
      end
      cnum = dy[DW-1] ? -dx : dx;
      cden = dy[DW-1] ? -dy : dy;
      if (cden != '0)      ccls = CLS_FINITE;
      else if (cnum > 0)   ccls = CLS_POSINF;
      else if (cnum < 0)   ccls = CLS_NEGINF;
      else                 ccls = CLS_NAN;
      lhs  = PW'(cnum) * PW'(bden_ff);
      rhs  = PW'(bnum_ff) * PW'(cden);
      if (ccls == CLS_NAN || bcls_ff == CLS_NAN) less = 1'b0;
      else if (ccls != bcls_ff)                  less = ccls < bcls_ff;
      else if (ccls == CLS_FINITE)               less = lhs < rhs;
      else                                       less = 1'b0;
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      best_in  = best_ff;
      bnum_in  = bnum_ff;
      bden_in  = bden_ff;
      bcls_in  = bcls_ff;
      unique case (ctl.cmd)
         CMD_STORE: begin
            if (count_ff < CNT_BITS'(MAX_POINTS)) count_in = count_ff + 1'b1;
            else                                  ovf_in   = 1'b1;
         end
         CMD_SET_REF: begin
            best_in = ctl.idx;
            bnum_in = cnum;
            bden_in = cden;
            bcls_in = ccls;
         end
         CMD_CAND: begin
            if (less) begin
               best_in = ctl.idx;
               bnum_in = cnum;
               bden_in = cden;
               bcls_in = ccls;
            end
         end
         CMD_COMMIT: pos_in = best_ff;
         CMD_CLEAR: begin
            count_in = '0;
            ovf_in   = 1'b0;
            pos_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pos_ff   <= pos_in;
      end
      best_ff <= best_in;
      bnum_ff <= bnum_in;
      bden_ff <= bden_in;
      bcls_ff <= bcls_in;
      if (ctl.cmd == CMD_SET_REF) begin
         ref_x_ff <= mem_x[pos_ff[IDX_BITS-1:0]];
         ref_y_ff <= mem_y[pos_ff[IDX_BITS-1:0]];
      end
      if (ctl.cmd == CMD_STORE && count_ff < CNT_BITS'(MAX_POINTS)) begin
         mem_x[count_ff[IDX_BITS-1:0]] <= in_x;
         mem_y[count_ff[IDX_BITS-1:0]] <= in_y;
      end
   end

   assign count       = count_ff;
   assign pos         = pos_ff;
   assign best_nan    = (bcls_ff == CLS_NAN);
   assign best_finite = (bcls_ff == CLS_FINITE);
   assign overflow    = ovf_ff;
   assign sel_x       = mem_x[pos_ff[IDX_BITS-1:0]];
   assign sel_y       = mem_y[pos_ff[IDX_BITS-1:0]];

endmodule

>>> sv/spch_ctrl.sv
// ----------------------------------------------------------------------------
// spch_ctrl
// Sequencer for load, downward and upward gift-wrapping walks and emission.
// ----------------------------------------------------------------------------
module spch_ctrl import spch_pkg::*; #(
   parameter int CNT_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_end,
   output logic                in_ready,
   input  logic [CNT_BITS-1:0] count,
   input  logic [CNT_BITS-1:0] pos,
   input  logic                best_nan,
   input  logic                best_finite,
   input  logic                out_free,    // output register can load
   output logic                emit,        // stage store[pos] as a result
   output logic                mark_last,   // send staged result as the final one
   output ctl_type             ctl
);
   state_type state_ff, state_in;
   logic [CNT_BITS-1:0] i_ff, i_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      in_ready    = 1'b0;
      emit        = 1'b0;
      mark_last   = 1'b0;
      ctl.cmd     = CMD_NONE;
      ctl.up      = 1'b0;
      ctl.idx     = '0;
      unique case (state_ff)
         ST_LOAD: begin
            in_ready = 1'b1;
            if (in_valid) begin
               ctl.cmd = CMD_STORE;
               if (in_end) state_in = ST_EMIT0;
            end
         end
         ST_EMIT0: begin
            // pos is 0 here
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_DN_INIT;
            end
         end
         ST_DN_INIT: begin
            if (count - pos > CNT_BITS'(1)) begin
               ctl.cmd  = CMD_SET_REF;
               ctl.idx  = count - 1'b1;
               i_in     = count - 1'b1;
               state_in = ST_DN_SCAN;
            end else begin
               state_in = ST_UP_INIT;
            end
         end
         ST_DN_SCAN: begin
            if (i_ff > pos + 1'b1) begin
               ctl.cmd = CMD_CAND;
               ctl.idx = i_ff - 1'b1;
               i_in    = i_ff - 1'b1;
            end else begin
               ctl.cmd  = CMD_COMMIT;
               state_in = ST_DN_DONE;
            end
         end
         ST_DN_DONE: begin
            if (best_nan) state_in = ST_DN_INIT;
            else if (out_free) begin
               emit     = 1'b1;
               state_in = ST_DN_INIT;
            end
         end
         ST_UP_INIT: begin
            if (pos != '0) begin
               ctl.cmd  = CMD_SET_REF;
               ctl.up   = 1'b1;
               ctl.idx  = '0;
               i_in     = CNT_BITS'(1);
               state_in = ST_UP_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_UP_SCAN: begin
            ctl.up = 1'b1;
            if (i_ff < pos) begin
               ctl.cmd = CMD_CAND;
               ctl.idx = i_ff;
               i_in    = i_ff + 1'b1;
            end else begin
               ctl.cmd  = CMD_COMMIT;
               state_in = ST_UP_DONE;
            end
         end
         ST_UP_DONE: begin
            if (pos == '0)        state_in = ST_FINISH;
            else if (!best_finite) state_in = ST_UP_INIT;
            else if (out_free) begin
               emit     = 1'b1;
               state_in = ST_UP_INIT;
            end
         end
         ST_FINISH: begin
            // staged result goes out flagged as the last one
            if (out_free) begin
               mark_last = 1'b1;
               ctl.cmd   = CMD_CLEAR;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

endmodule

>>> sv/sorted_point_convex_hull.sv
// ----------------------------------------------------------------------------
// sorted_point_convex_hull
// Gift-wrapping convex hull over a set of points sorted by y.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one point per beat: tdata = {point_y, point_x}, tlast marks
//   the final point of the set. Points load at one per cycle into a register
//   file. Points past MAX_POINTS are dropped and flagged on every result.
//   On tlast, req_tready drops and the walk runs: each downward step scans
//   the remaining points once, each upward step scans the points below pos,
//   and every compare goes through the single shared slope compare unit
//   (two multiplies per cycle). The FINISH and WAIT states close the set.
//   rsp_* delivers hull points: tdata = {hull_y, hull_x}, tuser =
//   points_dropped, tlast on the final hull point. Each chosen point waits in
//   a staging register until the next one is chosen or the walk ends, so
//   tlast is known when it moves to the output register; the walk waits
//   while the output register is full and rsp_tready is low.
//   Reset (synchronous, active high) empties the set and the output.
// ----------------------------------------------------------------------------
module sorted_point_convex_hull import spch_pkg::*; #(
   parameter int MAX_POINTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_y
   input  logic        req_tlast,   // set_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] hull_x, [31:16] hull_y
   output logic        rsp_tlast,   // hull_end
   output logic        rsp_tuser    // points_dropped
);
   localparam int IDX_BITS = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

   ctl_type             ctl;
   logic [CNT_BITS-1:0] count, pos;
   logic                best_nan, best_finite, overflow, emit, mark_last, out_free;
   logic                push;
   logic signed [COORD_BITS-1:0] sel_x, sel_y;

   logic        vld_ff, last_ff, drop_ff;
   logic [15:0] ox_ff, oy_ff;
   logic        stg_vld_ff, stg_drop_ff;
   logic [15:0] stg_x_ff, stg_y_ff;

   assign out_free = !vld_ff || rsp_tready;

   spch_ctrl #(.CNT_BITS(CNT_BITS)) u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_end(req_tlast), .in_ready(req_tready),
      .count, .pos, .best_nan, .best_finite,
      .out_free, .emit, .mark_last, .ctl
   );

   spch_datapath #(
      .MAX_POINTS(MAX_POINTS),
      .IDX_BITS(IDX_BITS), .CNT_BITS(CNT_BITS)
   ) u_dp (
      .clock, .reset, .ctl,
      .in_x(req_tdata[COORD_BITS-1:0]),
      .in_y(req_tdata[16 +: COORD_BITS]),
      .count, .pos, .best_nan, .best_finite, .overflow,
      .sel_x, .sel_y
   );

   // staged result moves out when a newer one is chosen or the walk ends
   assign push = (emit && stg_vld_ff) || mark_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         last_ff    <= 1'b0;
         stg_vld_ff <= 1'b0;
      end else begin
         if (push) begin
            vld_ff  <= 1'b1;
            last_ff <= mark_last;
         end else if (rsp_tready) begin
            vld_ff  <= 1'b0;
         end
         if (emit)           stg_vld_ff <= 1'b1;
         else if (mark_last) stg_vld_ff <= 1'b0;
      end
      if (push) begin
         ox_ff   <= stg_x_ff;
         oy_ff   <= stg_y_ff;
         drop_ff <= stg_drop_ff;
      end
      if (emit) begin
         stg_x_ff    <= 16'(sel_x);
         stg_y_ff    <= 16'(sel_y);
         stg_drop_ff <= overflow;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {oy_ff, ox_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = drop_ff;

`ifndef SYNTHESIS
   // no point taken while a walk is in progress or a non-final result is pending
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !vld_ff || last_ff)
      else $error("input taken during walk");
   // a result must not be overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && !rsp_tready) |-> !push)
      else $error("result overwritten");
   // final flag only goes with a staged result
   a_last_held: assert property (@(posedge clock) disable iff (reset)
      mark_last |-> stg_vld_ff)
      else $error("end flag without result");
`endif

endmodule

>>> verif/hull_checker.sv
// ----------------------------------------------------------------------------
// hull_checker
// Watches the point and hull streams, predicts each set's hull by gift
// wrapping with exact slope compares, and compares every hull beat.
// ----------------------------------------------------------------------------
module hull_checker import spch_pkg::*; #(
   parameter int MAX_POINTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          hulls_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        dropped;
      logic        last;
      logic [31:0] xy;
   } hull_beat_type;

   typedef struct {
      slope_cls_type cls;
      longint        num;
      longint        den;
   } slope_type;

   longint        pts_x[MAX_POINTS];
   longint        pts_y[MAX_POINTS];
   int            pts_n;
   bit            pts_over;
   hull_beat_type hull_q[$];

   function automatic slope_type slope_of(longint dx, longint dy);
      slope_type s;
      if (dy < 0) begin
         dx = -dx;
         dy = -dy;
      end
      s.num = dx;
      s.den = dy;
      if (dy != 0) s.cls = CLS_FINITE;
      else if (dx > 0) s.cls = CLS_POSINF;
      else if (dx < 0) s.cls = CLS_NEGINF;
      else s.cls = CLS_NAN;
      return s;
   endfunction

   // 0/0 is unordered; infinities compare by class
   function automatic bit slope_lt(slope_type a, slope_type b);
      if (a.cls == CLS_NAN || b.cls == CLS_NAN) return 0;
      if (a.cls != b.cls) return a.cls < b.cls;
      if (a.cls == CLS_FINITE) return a.num * b.den < b.num * a.den;
      return 0;
   endfunction

   function automatic void push_hull(int idx);
      hull_beat_type h;
      h.xy      = {pts_y[idx][15:0], pts_x[idx][15:0]};
      h.last    = 0;
      h.dropped = pts_over;
      hull_q.insert(hull_q.size(), h);
   endfunction

   function automatic void wrap_hull();
      int        pos, best, first;
      slope_type bs, cs;
      pos   = 0;
      first = hull_q.size();
      if (pts_n == 0) return;
      push_hull(0);
      while (pts_n - pos > 1) begin
         best = pts_n - 1;
         bs = slope_of(pts_x[best] - pts_x[pos], pts_y[best] - pts_y[pos]);
         for (int i = pts_n - 2; i > pos; i--) begin
            cs = slope_of(pts_x[i] - pts_x[pos], pts_y[i] - pts_y[pos]);
            if (slope_lt(cs, bs)) begin
               bs = cs;
               best = i;
            end
         end
         pos = best;
         if (bs.cls != CLS_NAN) push_hull(pos);
      end
      while (pos > 0) begin
         best = 0;
         bs = slope_of(pts_x[pos] - pts_x[0], pts_y[pos] - pts_y[0]);
         for (int i = 1; i < pos; i++) begin
            cs = slope_of(pts_x[pos] - pts_x[i], pts_y[pos] - pts_y[i]);
            if (slope_lt(cs, bs)) begin
               bs = cs;
               best = i;
            end
         end
         pos = best;
         if (pos == 0) break;
         if (bs.cls == CLS_FINITE) push_hull(pos);
      end
      if (hull_q.size() > first) hull_q[hull_q.size()-1].last = 1;
   endfunction

   always @(posedge clock) begin
      hull_beat_type want, got;
      if (reset) begin
         pts_n         = 0;
         pts_over      = 0;
         fail_count    <= 0;
         hulls_pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (pts_n < MAX_POINTS) begin
               pts_x[pts_n] = longint'($signed(req_tdata[15:0]));
               pts_y[pts_n] = longint'($signed(req_tdata[31:16]));
               pts_n = pts_n + 1;
            end else
               pts_over = 1;
            if (req_tlast) begin
               wrap_hull();
               pts_n = 0;
               pts_over = 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tlast, rsp_tdata};
            if (hull_q.size() == 0) begin
               $display("%t unexpected hull beat: expected none, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = hull_q.pop_front();
               if (want !== got) begin
                  $display("%t hull mismatch: expected %h, actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         hulls_pending <= hull_q.size();
      end
   end
endmodule

>>> verif/tb_sorted_point_convex_hull.sv
// ----------------------------------------------------------------------------
// tb_sorted_point_convex_hull
// Feeds sorted point sets (directed corners, then random sets) with random
// gaps and backpressure; the checker predicts and compares every hull beat.
// ----------------------------------------------------------------------------
module tb_sorted_point_convex_hull;
   import spch_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PTS     = 32;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] point_x, [31:16] point_y
   logic        req_tlast = 0;    // set_end
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;        // [15:0] hull_x, [31:16] hull_y
   logic        rsp_tlast;        // hull_end
   logic        rsp_tuser;        // points_dropped
   int          fail_count;
   int          hulls_pending;
   int          cycle_count = 0;
   bit          calm = 0;         // no idling on either side

   always #10 clock = ~clock;

   sorted_point_convex_hull #(.MAX_POINTS(MAX_PTS)) uut (.*);

   hull_checker #(.MAX_POINTS(MAX_PTS)) chk (.*);

   // sink side: random stalls except during the calm stretch
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 18);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one beat; optional idle cycles before it; tvalid stays up afterwards
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last_pt);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {y, x};
      req_tlast  <= last_pt;
      do @(posedge clock); while (!req_tready);
   endtask

   // random sorted set; y steps mostly small so duplicates and flats show up
   task automatic send_set(int n, int span);
      int y, x;
      y = -span + $urandom_range(span);
      for (int i = 0; i < n; i++) begin
         x = $urandom_range(2 * span) - span;
         if ($urandom_range(3) == 0) y = y;
         else y = y + $urandom_range(span / 4 + 1);
         if (y > 32767) y = 32767;
         send_point(x[15:0], y[15:0], i == n - 1);
      end
   endtask

   initial begin
      int sent;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: single point at extremes
      send_point(16'sh8000, 16'sh8000, 1);
      send_point(16'sh7fff, 16'sh7fff, 1);
      // two coincident points (0/0)
      send_point(5, 5, 0);
      send_point(5, 5, 1);
      // horizontal line, both infinities
      send_point(-3, 0, 0);
      send_point(3, 0, 0);
      send_point(0, 0, 1);
      // extreme diamond, full range differences
      send_point(0, -32768, 0);
      send_point(-32768, 0, 0);
      send_point(32767, 0, 0);
      send_point(0, 32767, 1);
      // collinear vertical
      send_point(1, 1, 0);
      send_point(1, 2, 0);
      send_point(1, 3, 1);
      // overflow: 34 points, last two dropped, the final one with tlast
      for (int i = 0; i < MAX_PTS + 2; i++)
         send_point(i[0] ? 16'sh7fff : 16'sh8000, i[15:0] - 16'sd17, i == MAX_PTS + 1);
      sent = 48;
      while (sent < 360) begin
         int n;
         calm = (sent > 150 && sent < 220);
         n = ($urandom_range(9) == 0) ? $urandom_range(MAX_PTS + 3, 20)
                                      : $urandom_range(8, 1);
         send_set(n, ($urandom_range(1) == 0) ? 8 : 32767);
         sent += n;
      end
      req_tvalid <= 0;
      calm = 0;
      @(posedge clock);
      while (hulls_pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
